// ----- rtl/core/ptw_pkg.sv -----
// Shared types, codes and lookup functions for the page table walker.
// No dependencies; every other file in rtl/core imports this package.
package ptw_pkg;

   localparam int unsigned VA_W       = 64;
   localparam int unsigned PA_W       = 52;
   localparam int unsigned DESC_W     = 64;
   localparam int unsigned BASE_W     = 48;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned IDX_W      = 16;

   localparam logic [1:0] LAST_LEVEL = 2'd3;

   // command of an input item
   localparam logic CMD_REQUEST = 1'b0;
   localparam logic CMD_DESC    = 1'b1;

   // kind of a result item
   localparam logic KIND_READ   = 1'b0;
   localparam logic KIND_RESULT = 1'b1;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_XLAT_FAULT = 2'd1;
   localparam logic [1:0] ST_PERM_FAULT = 2'd2;

   localparam logic [1:0] ACC_LOAD  = 2'd0;
   localparam logic [1:0] ACC_STORE = 2'd1;
   localparam logic [1:0] ACC_FETCH = 2'd2;

   localparam logic [1:0] DESC_BLOCK = 2'd1;
   localparam logic [1:0] DESC_TABLE = 2'd3;

   localparam logic [1:0] AP_PRIV_RW = 2'd0;
   localparam logic [1:0] AP_RW      = 2'd1;
   localparam logic [1:0] AP_PRIV_RO = 2'd2;
   localparam logic [1:0] AP_RO      = 2'd3;

   localparam int unsigned PERM_R = 0;
   localparam int unsigned PERM_W = 1;
   localparam int unsigned PERM_X = 2;

   // config register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TCR        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LOWER_BASE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_UPPER_BASE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PA_AT32    = 2'd3;

   typedef enum logic [1:0] {
      GRAN_4K  = 2'd0,
      GRAN_16K = 2'd1,
      GRAN_64K = 2'd2
   } granule_type;

   // PA size code -> output address bits, code 7 saturates
   localparam logic [5:0] PA_BITS [0:7] = '{6'd32, 6'd36, 6'd40, 6'd42,
                                            6'd44, 6'd48, 6'd52, 6'd52};

   // VA shift of the index at each level, level 0 first
   localparam logic [5:0] LVL_SHIFT_4K  [0:3] = '{6'd39, 6'd30, 6'd21, 6'd12};
   localparam logic [5:0] LVL_SHIFT_16K [0:3] = '{6'd47, 6'd36, 6'd25, 6'd14};
   localparam logic [5:0] LVL_SHIFT_64K [0:3] = '{6'd55, 6'd42, 6'd29, 6'd16};

   typedef struct packed {
      logic [VA_W-1:0]   tcr;
      logic [BASE_W-1:0] lower_base;
      logic [BASE_W-1:0] upper_base;
      logic              pa_at32;
   } cfg_type;

   typedef struct packed {
      logic                  en;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_wr_type;

   typedef struct packed {
      logic              cmd;
      logic [VA_W-1:0]   vaddr;
      logic [1:0]        access_kind;
      logic              user_mode;
      logic [DESC_W-1:0] desc_word;
   } req_item_type;

   typedef struct packed {
      logic            kind;
      logic [PA_W-1:0] mem_addr;
      logic [PA_W-1:0] xlat_addr;
      logic [2:0]      perms;
      logic [5:0]      page_shift;
      logic [1:0]      status;
      logic [1:0]      fault_level;
   } rsp_item_type;

   function automatic granule_type tg0_decode(input logic [1:0] tg);
      granule_type g;
      case (tg)
         2'd1:    g = GRAN_64K;
         2'd2:    g = GRAN_16K;
         default: g = GRAN_4K;
      endcase
      return g;
   endfunction

   function automatic granule_type tg1_decode(input logic [1:0] tg);
      granule_type g;
      case (tg)
         2'd1:    g = GRAN_16K;
         2'd3:    g = GRAN_64K;
         default: g = GRAN_4K;
      endcase
      return g;
   endfunction

   function automatic logic [5:0] granule_bits(input granule_type g);
      logic [5:0] b;
      case (g)
         GRAN_16K: b = 6'd14;
         GRAN_64K: b = 6'd16;
         default:  b = 6'd12;
      endcase
      return b;
   endfunction

   // index bits per table level
   function automatic logic [3:0] granule_stride(input granule_type g);
      logic [3:0] s;
      case (g)
         GRAN_16K: s = 4'd11;
         GRAN_64K: s = 4'd13;
         default:  s = 4'd9;
      endcase
      return s;
   endfunction

   function automatic logic [5:0] level_shift(input granule_type g, input logic [1:0] lvl);
      logic [5:0] s;
      case (g)
         GRAN_16K: s = LVL_SHIFT_16K[lvl];
         GRAN_64K: s = LVL_SHIFT_64K[lvl];
         default:  s = LVL_SHIFT_4K[lvl];
      endcase
      return s;
   endfunction

   function automatic logic [63:0] low_mask64(input logic [5:0] n);
      return ~({64{1'b1}} << n);
   endfunction

endpackage

// ----- rtl/core/ptw_if.sv -----
// Valid/ready channel interfaces of the page table walker: request,
// response and config write. Depends on ptw_pkg for field widths.
interface ptw_req_if;
   import ptw_pkg::*;
   logic                valid;
   logic                ready;
   logic                cmd;
   logic [VA_W-1:0]     vaddr;
   logic [1:0]          access_kind;
   logic                user_mode;
   logic [DESC_W-1:0]   desc_word;

   modport source (output valid, cmd, vaddr, access_kind, user_mode, desc_word,
                   input ready);
   modport sink   (input valid, cmd, vaddr, access_kind, user_mode, desc_word,
                   output ready);
endinterface

interface ptw_rsp_if;
   import ptw_pkg::*;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [PA_W-1:0]   mem_addr;
   logic [PA_W-1:0]   xlat_addr;
   logic [2:0]        perms;
   logic [5:0]        page_shift;
   logic [1:0]        status;
   logic [1:0]        fault_level;

   modport source (output valid, kind, mem_addr, xlat_addr, perms, page_shift, status,
                   fault_level, input ready);
   modport sink   (input valid, kind, mem_addr, xlat_addr, perms, page_shift, status,
                   fault_level, output ready);
endinterface

interface ptw_csr_if;
   import ptw_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/page_table_walker_core.sv -----
// Top level of the stage-one page table walker: input register, walk step,
// result register and config registers. Depends on ptw_pkg, ptw_if,
// ptw_csr and ptw_walk.
//
//   channel  | modport | carries
//   ---------+---------+-------------------------------------------------
//   req_ch   | sink    | new request (cmd 0) or returned descriptor (cmd 1)
//   rsp_ch   | source  | descriptor read address or final translation
//   csr_ch   | sink    | config write: index, data (always ready)
//
// One item per cycle while rsp_ch does not stall; a result is valid on rsp_ch once its
// item has passed the input register, then the result register after the step logic.
// A descriptor that arrives with no walk running is dropped, no result.
// A stall on rsp_ch holds the result register and backs up into the input
// register; req_ch stays ready while the result register drains.
// Synchronous reset clears walk busy/level/granule/PA code and config, sets pa_at32.
module page_table_walker_core (
   input logic        clock,
   input logic        reset,
   ptw_req_if.sink    req_ch,
   ptw_rsp_if.source  rsp_ch,
   ptw_csr_if.sink    csr_ch
);
   import ptw_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;

   logic         advance;
   logic         req_take;
   req_item_type req_item;
   cfg_type      cfg;
   csr_wr_type   csr_wr;
   logic         res_valid;
   rsp_item_type res;

   assign req_item.cmd         = req_ch.cmd;
   assign req_item.vaddr       = req_ch.vaddr;
   assign req_item.access_kind = req_ch.access_kind;
   assign req_item.user_mode   = req_ch.user_mode;
   assign req_item.desc_word   = req_ch.desc_word;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = (out_valid_ff && !rsp_ch.ready) || (advance && res_valid);

   assign csr_ch.ready = 1'b1;
   assign csr_wr.en    = csr_ch.valid;
   assign csr_wr.index = csr_ch.index;
   assign csr_wr.data  = csr_ch.data;

   ptw_csr u_csr (
      .clock (clock),
      .reset (reset),
      .wr    (csr_wr),
      .cfg   (cfg)
   );

   ptw_walk u_walk (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .item       (in_item_ff),
      .cfg        (cfg),
      .res_valid  (res_valid),
      .res        (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (advance && res_valid) begin
         out_item_ff <= res;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.kind        = out_item_ff.kind;
   assign rsp_ch.mem_addr    = out_item_ff.mem_addr;
   assign rsp_ch.xlat_addr   = out_item_ff.xlat_addr;
   assign rsp_ch.perms       = out_item_ff.perms;
   assign rsp_ch.page_shift  = out_item_ff.page_shift;
   assign rsp_ch.status      = out_item_ff.status;
   assign rsp_ch.fault_level = out_item_ff.fault_level;

endmodule

// ----- rtl/core/ptw_csr.sv -----
// Config register file of the page table walker.
// Depends on ptw_pkg (cfg_type, csr_wr_type, register indexes).
module ptw_csr (
   input  logic              clock,
   input  logic              reset,
   input  ptw_pkg::csr_wr_type wr,
   output ptw_pkg::cfg_type  cfg
);
   import ptw_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr.en) begin
         case (wr.index)
            REG_TCR:        cfg_in.tcr        = wr.data;
            REG_LOWER_BASE: cfg_in.lower_base = wr.data[BASE_W-1:0];
            REG_UPPER_BASE: cfg_in.upper_base = wr.data[BASE_W-1:0];
            REG_PA_AT32:    cfg_in.pa_at32    = wr.data[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tcr        <= '0;
         cfg_ff.lower_base <= '0;
         cfg_ff.upper_base <= '0;
         cfg_ff.pa_at32    <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/ptw_walk.sv -----
// Walk state and single-pass step logic: one request or descriptor per cycle
// of step_valid gives a descriptor read or final result. Depends on ptw_pkg.
module ptw_walk (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_valid,
   input  ptw_pkg::req_item_type item,
   input  ptw_pkg::cfg_type      cfg,
   output logic                  res_valid,
   output ptw_pkg::rsp_item_type res
);
   import ptw_pkg::*;

   // walk state
   logic              busy_ff, busy_in;
   logic [VA_W-1:0]   vaddr_ff, vaddr_in;
   logic [1:0]        access_ff, access_in;
   logic              user_ff, user_in;
   logic [1:0]        level_ff, level_in;
   granule_type       gran_ff, gran_in;
   logic [2:0]        pa_code_ff, pa_code_in;

   // new request decode
   logic              upper;
   logic [5:0]        tsz;
   granule_type       req_gran;
   logic [PA_W-1:0]   req_base;
   logic [6:0]        insize_raw;
   logic [5:0]        insize;
   logic [1:0]        start_lvl;
   logic [5:0]        start_sh;
   logic [3:0]        start_w;
   logic [2:0]        req_pa_code;

   // descriptor decode
   logic [1:0]        entry_kind;
   logic [63:0]       pa_mask64;
   logic [63:0]       g_mask64;
   logic [63:0]       vs_mask64;
   logic [1:0]        next_lvl;
   logic [5:0]        cur_sh;
   logic [1:0]        ap;
   logic              uxn;
   logic              pxn;
   logic [2:0]        perms;
   logic              allowed;
   logic              ok;
   logic [PA_W-1:0]   phys;

   // descriptor read address
   logic [VA_W-1:0]   rd_va;
   logic [5:0]        rd_sh;
   logic [3:0]        rd_w;
   logic [PA_W-1:0]   rd_base;
   logic [1:0]        rd_lvl;
   logic [63:0]       idx_mask64;
   logic [VA_W-1:0]   rd_shifted;
   logic [IDX_W-1:0]  rd_idx;
   logic [PA_W-1:0]   rd_addr;

   always_comb begin
      upper = item.vaddr[55];
      if (upper) begin
         tsz      = cfg.tcr[21:16];
         req_gran = tg1_decode(cfg.tcr[31:30]);
         req_base = {{(PA_W-BASE_W){1'b0}}, cfg.upper_base[BASE_W-1:1], 1'b0};
      end else begin
         tsz      = cfg.tcr[5:0];
         req_gran = tg0_decode(cfg.tcr[15:14]);
         req_base = {{(PA_W-BASE_W){1'b0}}, cfg.lower_base[BASE_W-1:1], 1'b0};
      end
      insize_raw = 7'd64 - {1'b0, tsz};
      if (insize_raw > 7'd48)      insize = 6'd48;
      else if (insize_raw < 7'd25) insize = 6'd25;
      else                         insize = insize_raw[5:0];

      // start at the first level whose index shift lies below the region size
      if (insize > level_shift(req_gran, 2'd0))      start_lvl = 2'd0;
      else if (insize > level_shift(req_gran, 2'd1)) start_lvl = 2'd1;
      else if (insize > level_shift(req_gran, 2'd2)) start_lvl = 2'd2;
      else                                           start_lvl = 2'd3;
      start_sh    = level_shift(req_gran, start_lvl);
      start_w     = 4'(insize - start_sh);
      req_pa_code = cfg.pa_at32 ? cfg.tcr[34:32] : cfg.tcr[18:16];

      entry_kind = item.desc_word[1:0];
      pa_mask64 = low_mask64(PA_BITS[pa_code_ff]);
      g_mask64  = low_mask64(granule_bits(gran_ff));
      next_lvl  = level_ff + 2'd1;
      cur_sh    = level_shift(gran_ff, level_ff);
      vs_mask64 = low_mask64(cur_sh);

      if (item.cmd == CMD_REQUEST) begin
         rd_va   = item.vaddr;
         rd_sh   = start_sh;
         rd_w    = start_w;
         rd_base = req_base;
         rd_lvl  = start_lvl;
      end else begin
         rd_va   = vaddr_ff;
         rd_sh   = level_shift(gran_ff, next_lvl);
         rd_w    = granule_stride(gran_ff);
         rd_base = item.desc_word[PA_W-1:0] & pa_mask64[PA_W-1:0] & ~g_mask64[PA_W-1:0];
         rd_lvl  = next_lvl;
      end
      idx_mask64 = low_mask64({2'b00, rd_w});
      rd_shifted = rd_va >> rd_sh;
      rd_idx     = rd_shifted[IDX_W-1:0] & idx_mask64[IDX_W-1:0];
      rd_addr    = rd_base + {{(PA_W-IDX_W-3){1'b0}}, rd_idx, 3'b000};

      // leaf checks
      ok = (entry_kind == DESC_TABLE)
         || ((entry_kind == DESC_BLOCK)
             && ((level_ff == 2'd2) || ((level_ff == 2'd1) && (gran_ff == GRAN_4K))));
      phys = (item.desc_word[PA_W-1:0] & pa_mask64[PA_W-1:0] & ~vs_mask64[PA_W-1:0])
           | (vaddr_ff[PA_W-1:0] & vs_mask64[PA_W-1:0]);
      ap  = item.desc_word[7:6];
      uxn = item.desc_word[54];
      pxn = item.desc_word[53];
      case (ap)
         AP_PRIV_RW: perms = user_ff ? 3'b000 : 3'b011;
         AP_RW:      perms = 3'b011;
         AP_PRIV_RO: perms = user_ff ? 3'b000 : 3'b001;
         AP_RO:      perms = 3'b001;
         default:    perms = 3'b000;
      endcase
      if ((user_ff && !uxn) || (!user_ff && !pxn)) perms[PERM_X] = 1'b1;
      case (access_ff)
         ACC_STORE: allowed = perms[PERM_W];
         ACC_FETCH: allowed = perms[PERM_X];
         default:   allowed = perms[PERM_R];
      endcase

      busy_in    = busy_ff;
      vaddr_in   = vaddr_ff;
      access_in  = access_ff;
      user_in    = user_ff;
      level_in   = level_ff;
      gran_in    = gran_ff;
      pa_code_in = pa_code_ff;
      res        = '0;
      res_valid  = 1'b0;

      case (item.cmd)
         CMD_REQUEST: begin
            // a request while busy abandons the running walk
            busy_in          = 1'b1;
            vaddr_in         = item.vaddr;
            access_in        = item.access_kind;
            user_in          = item.user_mode;
            level_in         = start_lvl;
            gran_in          = req_gran;
            pa_code_in       = req_pa_code;
            res_valid        = step_valid;
            res.kind         = KIND_READ;
            res.mem_addr     = rd_addr;
            res.fault_level  = rd_lvl;
         end
         CMD_DESC: begin
            if (busy_ff) begin
               res_valid = step_valid;
               if ((entry_kind == DESC_TABLE) && (level_ff < LAST_LEVEL)) begin
                  level_in        = next_lvl;
                  res.kind        = KIND_READ;
                  res.mem_addr    = rd_addr;
                  res.fault_level = rd_lvl;
               end else begin
                  busy_in         = 1'b0;
                  res.kind        = KIND_RESULT;
                  res.fault_level = level_ff;
                  if (!ok) begin
                     res.status = ST_XLAT_FAULT;
                  end else if (!allowed) begin
                     res.status = ST_PERM_FAULT;
                  end else begin
                     res.status     = ST_OK;
                     res.xlat_addr  = phys;
                     res.perms      = perms;
                     res.page_shift = cur_sh;
                  end
               end
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         level_ff   <= '0;
         gran_ff    <= GRAN_4K;
         pa_code_ff <= '0;
      end else if (step_valid) begin
         busy_ff    <= busy_in;
         level_ff   <= level_in;
         gran_ff    <= gran_in;
         pa_code_ff <= pa_code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_valid) begin
         vaddr_ff  <= vaddr_in;
         access_ff <= access_in;
         user_ff   <= user_in;
      end
   end

endmodule

// ----- rtl/core/ptw_checker.sv -----
// Port-level checks on the walker's response channel, bound to the top level.
// Depends on ptw_pkg and page_table_walker_core.
module ptw_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_kind,
   input logic [ptw_pkg::PA_W-1:0] rsp_mem_addr,
   input logic [ptw_pkg::PA_W-1:0] rsp_xlat_addr,
   input logic [2:0]           rsp_perms,
   input logic [5:0]           rsp_page_shift,
   input logic [1:0]           rsp_status
);
   import ptw_pkg::*;

   // a stalled item stays in place
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_mem_addr) && $stable(rsp_xlat_addr) && $stable(rsp_status))
      else $error("response changed while stalled");

   // nothing can come out in the cycle right after reset
   a_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_read_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_READ) |->
         (rsp_status == ST_OK) && (rsp_xlat_addr == '0) && (rsp_perms == '0)
         && (rsp_page_shift == '0))
      else $error("descriptor read carries result fields");

   a_fault_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_RESULT) && (rsp_status != ST_OK) |->
         ((rsp_status == ST_XLAT_FAULT) || (rsp_status == ST_PERM_FAULT))
         && (rsp_xlat_addr == '0) && (rsp_perms == '0) && (rsp_page_shift == '0)
         && (rsp_mem_addr == '0))
      else $error("fault result carries translation fields");

   // a success passed the access check, so some permission is set
   a_success_perms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_RESULT) && (rsp_status == ST_OK) |->
         (rsp_perms != '0) && (rsp_page_shift != '0) && (rsp_mem_addr == '0))
      else $error("successful translation without permissions or page size");

endmodule

bind page_table_walker_core ptw_checker u_ptw_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_kind       (rsp_ch.kind),
   .rsp_mem_addr   (rsp_ch.mem_addr),
   .rsp_xlat_addr  (rsp_ch.xlat_addr),
   .rsp_perms      (rsp_ch.perms),
   .rsp_page_shift (rsp_ch.page_shift),
   .rsp_status     (rsp_ch.status)
);

// ----- tb/tb_page_table_walker_core.sv -----
// Self-checking bench for page_table_walker_core: directed and random translation walks
// checked against an in-bench walk predictor, with random idling and a long result stall.
// Depends on ptw_pkg, ptw_if and the core RTL.
module tb_page_table_walker_core;
   import ptw_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   // granule field codes, TG0 and TG1 differ
   localparam logic [1:0] TG0_4K   = 2'd0;
   localparam logic [1:0] TG0_64K  = 2'd1;
   localparam logic [1:0] TG0_16K  = 2'd2;
   localparam logic [1:0] TG0_RSVD = 2'd3;
   localparam logic [1:0] TG1_RSVD = 2'd0;
   localparam logic [1:0] TG1_16K  = 2'd1;
   localparam logic [1:0] TG1_4K   = 2'd2;
   localparam logic [1:0] TG1_64K  = 2'd3;

   localparam logic [1:0] DESC_INVALID  = 2'd0;
   localparam logic [1:0] DESC_RESERVED = 2'd2;
   localparam logic [1:0] ACC_RSVD      = 2'd3;

   logic clock = 1'b0;
   logic reset;

   ptw_req_if req_ch ();
   ptw_rsp_if rsp_ch ();
   ptw_csr_if csr_ch ();

   page_table_walker_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #10 clock = ~clock;

   // register copies
   logic [63:0] cfg_tcr;
   logic [47:0] cfg_lower;
   logic [47:0] cfg_upper;
   logic        cfg_at32;

   // walk state copy
   logic        walk_busy;
   logic [63:0] walk_va;
   logic [1:0]  walk_acc;
   logic        walk_user;
   logic [1:0]  walk_lvl;
   logic [51:0] walk_base;
   int unsigned walk_gran;
   logic [2:0]  walk_pa_code;

   rsp_item_type walk_out_q[$];

   int  fail_count  = 0;
   int  items_sent  = 0;
   int  reads_seen  = 0;
   int  ok_seen     = 0;
   int  xlat_seen   = 0;
   int  perm_seen   = 0;
   int  cycle_count = 0;
   int  hold_left   = 0;
   bit  quiet       = 1'b0;

   function automatic logic [63:0] bit_mask(input int unsigned n);
      return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
   endfunction

   function automatic int unsigned va_shift(input int unsigned g, input logic [1:0] lvl);
      return g + (int'(LAST_LEVEL) - int'(lvl)) * (g - 3);
   endfunction

   function automatic int unsigned pa_width(input logic [2:0] code);
      case (code)
         3'd0:    return 32;
         3'd1:    return 36;
         3'd2:    return 40;
         3'd3:    return 42;
         3'd4:    return 44;
         3'd5:    return 48;
         default: return 52;
      endcase
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic void queue_read(input int unsigned idx_bits);
      rsp_item_type r;
      logic [63:0]  idx;
      logic [63:0]  addr;
      r = '0;
      idx = (walk_va >> va_shift(walk_gran, walk_lvl)) & bit_mask(idx_bits);
      addr = {12'b0, walk_base} + idx * 64'd8;
      r.kind = KIND_READ;
      r.mem_addr = addr[51:0];
      r.fault_level = walk_lvl;
      walk_out_q.push_back(r);
   endfunction

   // advances the walk copy by one item; returns 1 when the item makes a result
   function automatic bit walk_step(input req_item_type it);
      int unsigned  tsz, g, insize, stride, levels, sh, w, pab, vs;
      logic [1:0]   dtype;
      logic [63:0]  d, t, pa;
      logic [2:0]   p;
      logic         ok, allowed;
      rsp_item_type r;
      if (it.cmd == CMD_REQUEST) begin
         if (it.vaddr[55]) begin
            tsz = 32'(cfg_tcr[21:16]);
            case (cfg_tcr[31:30])
               TG1_16K: g = 14;
               TG1_64K: g = 16;
               default: g = 12;
            endcase
            walk_base = {4'b0, cfg_upper & ~48'd1};
         end else begin
            tsz = 32'(cfg_tcr[5:0]);
            case (cfg_tcr[15:14])
               TG0_64K: g = 16;
               TG0_16K: g = 14;
               default: g = 12;
            endcase
            walk_base = {4'b0, cfg_lower & ~48'd1};
         end
         insize = 64 - tsz;
         if (insize > 48) insize = 48;
         if (insize < 25) insize = 25;
         stride = g - 3;
         levels = (insize - g + stride - 1) / stride;
         if (levels > 4) levels = 4;
         if (levels < 1) levels = 1;
         walk_pa_code = cfg_at32 ? cfg_tcr[34:32] : cfg_tcr[18:16];
         walk_va = it.vaddr;
         walk_acc = it.access_kind;
         walk_user = it.user_mode;
         walk_gran = g;
         walk_lvl = 2'(4 - levels);
         walk_busy = 1'b1;
         sh = va_shift(g, walk_lvl);
         // start level index only uses VA bits below the region size
         w = (insize > sh) ? insize - sh : 1;
         if (w > stride) w = stride;
         queue_read(w);
         return 1'b1;
      end
      if (!walk_busy) return 1'b0;
      d = it.desc_word;
      dtype = d[1:0];
      pab = pa_width(walk_pa_code);
      if (dtype == DESC_TABLE && walk_lvl < LAST_LEVEL) begin
         t = d & bit_mask(pab) & ~bit_mask(walk_gran);
         walk_base = t[51:0];
         walk_lvl = walk_lvl + 2'd1;
         queue_read(walk_gran - 3);
         return 1'b1;
      end
      walk_busy = 1'b0;
      r = '0;
      r.kind = KIND_RESULT;
      r.fault_level = walk_lvl;
      ok = (dtype == DESC_TABLE) ||
           (dtype == DESC_BLOCK && (walk_lvl == 2'd2 || (walk_lvl == 2'd1 && walk_gran == 12)));
      if (!ok) begin
         r.status = ST_XLAT_FAULT;
      end else begin
         vs = va_shift(walk_gran, walk_lvl);
         pa = (d & bit_mask(pab) & ~bit_mask(vs)) | (walk_va & bit_mask(vs));
         p = '0;
         case (d[7:6])
            AP_PRIV_RW: begin
               p[PERM_R] = !walk_user;
               p[PERM_W] = !walk_user;
            end
            AP_RW: begin
               p[PERM_R] = 1'b1;
               p[PERM_W] = 1'b1;
            end
            AP_PRIV_RO: p[PERM_R] = !walk_user;
            default:    p[PERM_R] = 1'b1;
         endcase
         p[PERM_X] = walk_user ? !d[54] : !d[53];
         case (walk_acc)
            ACC_STORE: allowed = p[PERM_W];
            ACC_FETCH: allowed = p[PERM_X];
            default:   allowed = p[PERM_R];
         endcase
         if (!allowed) begin
            r.status = ST_PERM_FAULT;
         end else begin
            r.status = ST_OK;
            r.xlat_addr = pa[51:0];
            r.perms = p;
            r.page_shift = 6'(vs);
         end
      end
      walk_out_q.push_back(r);
      return 1'b1;
   endfunction

   function automatic string rsp_text(input rsp_item_type r);
      return $sformatf("kind=%0d mem=%h phys=%h perms=%0d shift=%0d status=%0d level=%0d",
                       r.kind, r.mem_addr, r.xlat_addr, r.perms, r.page_shift, r.status,
                       r.fault_level);
   endfunction

   function automatic void log_failure(input string what, input rsp_item_type want,
                                       input rsp_item_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("[%0d] %s", cycle_count, what);
         $display("   expected %s", rsp_text(want));
         $display("   actual   %s", rsp_text(got));
      end
   endfunction

   // result side: ready with random stalls unless quiet, or held off while hold_left counts down
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= 16);
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.kind = rsp_ch.kind;
         got.mem_addr = rsp_ch.mem_addr;
         got.xlat_addr = rsp_ch.xlat_addr;
         got.perms = rsp_ch.perms;
         got.page_shift = rsp_ch.page_shift;
         got.status = rsp_ch.status;
         got.fault_level = rsp_ch.fault_level;
         if (walk_out_q.size() == 0) begin
            log_failure("result item with nothing outstanding", '0, got);
         end else begin
            want = walk_out_q.pop_front();
            if (got.kind !== want.kind || got.mem_addr !== want.mem_addr ||
                got.xlat_addr !== want.xlat_addr || got.perms !== want.perms ||
                got.page_shift !== want.page_shift || got.status !== want.status ||
                got.fault_level !== want.fault_level)
               log_failure("result item mismatch", want, got);
            if (want.kind == KIND_READ) reads_seen++;
            else if (want.status == ST_OK) ok_seen++;
            else if (want.status == ST_XLAT_FAULT) xlat_seen++;
            else perm_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", walk_out_q.size());
         $display("** page_table_walker_core: FAILED **");
         $finish;
      end
   end

   task automatic send_item(input req_item_type it);
      if (!quiet && $urandom_range(0, 99) < 16) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= it.cmd;
      req_ch.vaddr <= it.vaddr;
      req_ch.access_kind <= it.access_kind;
      req_ch.user_mode <= it.user_mode;
      req_ch.desc_word <= it.desc_word;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (walk_step(it)) items_sent++;
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         REG_TCR:        cfg_tcr = data;
         REG_LOWER_BASE: cfg_lower = data[47:0];
         REG_UPPER_BASE: cfg_upper = data[47:0];
         default:        cfg_at32 = data[0];
      endcase
   endtask

   // unused upper bits of the base and PA_AT32 writes are random
   task automatic write_config(input logic [63:0] tcr, input logic [47:0] lo,
                               input logic [47:0] hi, input logic at32);
      logic [63:0] junk;
      junk = rand64();
      csr_write(REG_TCR, tcr);
      csr_write(REG_LOWER_BASE, {junk[63:48], lo});
      csr_write(REG_UPPER_BASE, {junk[47:32], hi});
      csr_write(REG_PA_AT32, {junk[62:0], at32});
      csr_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (walk_out_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic req_item_type new_request(input logic [63:0] va, input logic [1:0] acc,
                                                input logic user);
      req_item_type it;
      it.cmd = CMD_REQUEST;
      it.vaddr = va;
      it.access_kind = acc;
      it.user_mode = user;
      it.desc_word = rand64();
      return it;
   endfunction

   function automatic req_item_type new_desc(input logic [63:0] d);
      req_item_type it;
      it.cmd = CMD_DESC;
      it.vaddr = rand64();
      it.access_kind = 2'($urandom_range(0, 3));
      it.user_mode = 1'($urandom_range(0, 1));
      it.desc_word = d;
      return it;
   endfunction

   function automatic logic [63:0] leaf_desc(input logic [1:0] dtype, input logic [1:0] ap,
                                             input logic pxn, input logic uxn);
      logic [63:0] d;
      d = rand64();
      d[1:0] = dtype;
      d[7:6] = ap;
      d[53] = pxn;
      d[54] = uxn;
      return d;
   endfunction

   // descriptor that mostly keeps the running walk going deeper
   function automatic logic [63:0] next_desc();
      logic [63:0] d;
      int          pick;
      d = rand64();
      pick = $urandom_range(0, 99);
      if (walk_lvl < LAST_LEVEL) begin
         if (pick < 70) d[1:0] = DESC_TABLE;
         else if (pick < 90) d[1:0] = DESC_BLOCK;
      end else if (pick < 85) begin
         d[1:0] = DESC_TABLE;
      end
      return d;
   endfunction

   task automatic run_walk(input int max_descs);
      int n;
      n = 0;
      send_item(new_request(rand64(), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
      while (walk_busy && n < max_descs) begin
         send_item(new_desc(next_desc()));
         n++;
      end
   endtask

   task automatic random_phase(input logic [63:0] tcr, input logic [47:0] lo,
                               input logic [47:0] hi, input logic at32, input int count);
      int goal;
      int pick;
      wait_drained();
      write_config(tcr, lo, hi, at32);
      goal = items_sent + count;
      while (items_sent < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) run_walk(4);
         else if (pick < 92) run_walk($urandom_range(0, 2));
         else send_item(new_desc(rand64()));
      end
   endtask

   task automatic test_directed();
      logic [63:0] tcr;
      tcr = '0;
      tcr[34:32] = 3'd7;          // PA size code that saturates
      tcr[15:14] = TG0_RSVD;      // both granule fields reserved -> 4K
      tcr[31:30] = TG1_RSVD;
      write_config(tcr, '1, '1, 1'b1);
      send_item(new_desc(rand64()));                      // no walk running: dropped
      // upper region, full 48-bit region, 1G block at level 1
      send_item(new_request('1, ACC_RSVD, 1'b1));
      send_item(new_desc('1));
      send_item(new_desc(leaf_desc(DESC_BLOCK, AP_RO, 1'b1, 1'b0)));
      // fetch denied by PXN on a level 2 block
      send_item(new_request('0, ACC_FETCH, 1'b0));
      send_item(new_desc(leaf_desc(DESC_TABLE, AP_PRIV_RW, 1'b0, 1'b0)));
      send_item(new_desc(leaf_desc(DESC_TABLE, AP_PRIV_RW, 1'b0, 1'b0)));
      send_item(new_desc(leaf_desc(DESC_BLOCK, AP_PRIV_RW, 1'b1, 1'b0)));
      // invalid and reserved descriptor types
      send_item(new_request(rand64(), ACC_STORE, 1'b1));
      send_item(new_desc('0));
      send_item(new_request(rand64(), ACC_LOAD, 1'b0));
      send_item(new_desc(leaf_desc(DESC_TABLE, AP_RW, 1'b0, 1'b0)));
      send_item(new_desc(leaf_desc(DESC_RESERVED, AP_RW, 1'b0, 1'b0)));
      // block at level 0 is not allowed
      send_item(new_request(rand64(), ACC_LOAD, 1'b0));
      send_item(new_desc(leaf_desc(DESC_BLOCK, AP_RW, 1'b0, 1'b0)));
      // second request abandons the first, then a full walk to a page
      send_item(new_request(rand64(), ACC_STORE, 1'b0));
      send_item(new_request(rand64(), ACC_LOAD, 1'b1));
      send_item(new_desc(leaf_desc(DESC_TABLE, AP_RW, 1'b0, 1'b0)));
      send_item(new_desc(leaf_desc(DESC_TABLE, AP_RW, 1'b0, 1'b0)));
      send_item(new_desc(leaf_desc(DESC_TABLE, AP_RW, 1'b0, 1'b0)));
      send_item(new_desc(leaf_desc(DESC_TABLE, AP_RW, 1'b0, 1'b0)));
      wait_drained();
   endtask

   task automatic test_random_walks();
      random_phase('0, '0, '0, 1'b0, 280);
      random_phase('1, '1, '1, 1'b1, 280);
      for (int k = 0; k < 4; k++) begin
         quiet = (k == 2);
         random_phase(rand64(), 48'(rand64()), 48'(rand64()), 1'($urandom_range(0, 1)), 280);
      end
      quiet = 1'b0;
   endtask

   // results held off while walks keep coming, so the input side backs up
   task automatic test_backpressure();
      int goal;
      wait_drained();
      write_config(rand64(), 48'(rand64()), 48'(rand64()), 1'($urandom_range(0, 1)));
      hold_left = 300;
      goal = items_sent + 100;
      while (items_sent < goal) run_walk(4);
      wait_drained();
   endtask

   initial begin
      int waited;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_REQUEST;
      req_ch.vaddr = '0;
      req_ch.access_kind = ACC_LOAD;
      req_ch.user_mode = 1'b0;
      req_ch.desc_word = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_TCR;
      csr_ch.data = '0;
      cfg_tcr = '0;
      cfg_lower = '0;
      cfg_upper = '0;
      cfg_at32 = 1'b1;
      walk_busy = 1'b0;
      walk_va = '0;
      walk_acc = ACC_LOAD;
      walk_user = 1'b0;
      walk_lvl = '0;
      walk_base = '0;
      walk_gran = 12;
      walk_pa_code = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_walks();
      test_backpressure();

      req_ch.valid <= 1'b0;
      waited = 0;
      while (walk_out_q.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (walk_out_q.size() != 0) begin
         $display("%0d expected results never arrived", walk_out_q.size());
         fail_count += walk_out_q.size();
      end

      $display("coverage: %0d items walked, %0d descriptor reads, %0d translations",
               items_sent, reads_seen, ok_seen);
      $display("          %0d translation faults, %0d permission faults, %0d failures",
               xlat_seen, perm_seen, fail_count);
      if (fail_count == 0)
         $display("** page_table_walker_core: PASSED **");
      else
         $display("** page_table_walker_core: FAILED **");
      $finish;
   end

endmodule
